>>> hdl/aba_pkg.sv
// shared types and constants for the aligned bump allocator
// no dependencies; used by aligned_bump_allocator_top and the testbench

package aba_pkg;

   localparam int FIELD_BITS  = 24;
   localparam int ADDR_BITS   = 48;
   localparam int OFFSET_BITS = 24;
   localparam int ROUND_BITS  = FIELD_BITS + 1;
   localparam int SUM_BITS    = FIELD_BITS + 2;
   localparam int DIV_STEPS   = ROUND_BITS;
   localparam int CNT_BITS    = $clog2(DIV_STEPS);
   localparam int CSR_IDX_BITS = 2;

   // operation codes
   localparam logic [1:0] KIND_POW2  = 2'd0;
   localparam logic [1:0] KIND_ANY   = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;
   localparam logic [1:0] KIND_NOP   = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OOM      = 2'd1;
   localparam logic [1:0] STATUS_NOT_POW2 = 2'd2;
   localparam logic [1:0] STATUS_ZERO     = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAPACITY = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE     = CSR_IDX_BITS'(1);

   localparam logic [FIELD_BITS-1:0] CAPACITY_RESET = '1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_DIV_SIZE,
      S_DIV_OFS,
      S_CHECK
   } state_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [FIELD_BITS-1:0] request_bytes;
      logic [FIELD_BITS-1:0] align_bytes;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [FIELD_BITS-1:0] block_offset;
      logic [FIELD_BITS-1:0] block_bytes;
      logic [ADDR_BITS-1:0]  device_address;
   } rsp_type;

endpackage

>>> hdl/aligned_bump_allocator_top.sv
// aligned bump allocator: one running offset over a configured byte region
// depends on aba_pkg (types, codes, widths)

// Linear allocator that hands out blocks from a region of capacity_bytes bytes
// starting at device address region_base. Each request beat carries a kind:
// power-of-two aligned allocate (mask rounding), any-alignment allocate
// (rounding through a bit-serial restoring divider), a clear of the running
// offset or an unused no-op kind. One request is worked on at a time; req_ready
// is high only while the sequencer is idle. From S_DECODE, clear, unused kind
// and alignment errors load the response register directly, power-of-two
// allocate goes on through S_CHECK, and any-alignment allocate goes through
// S_DIV_SIZE and S_DIV_OFS to S_CHECK, using the shared divider which retires
// one quotient bit per cycle and is run twice (once for the size, once for
// the offset). The response sits in an output register, so the next request
// may be accepted while a response beat still waits for rsp_ready; a finished
// request holds in its last state until that register frees. Configuration
// writes (csr_index 0 capacity, 1 region base, others ignored) are always
// taken and must only be issued while no request is outstanding.

module aligned_bump_allocator_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  aba_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output aba_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [aba_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [aba_pkg::ADDR_BITS-1:0]         csr_wdata
);

   // control state
   aba_pkg::state_type                  state_ff, state_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [aba_pkg::OFFSET_BITS-1:0]     next_ofs_ff, next_ofs_in;
   logic [aba_pkg::FIELD_BITS-1:0]      cap_ff;
   logic [aba_pkg::ADDR_BITS-1:0]       base_ff;
   logic [aba_pkg::CNT_BITS-1:0]        div_cnt_ff, div_cnt_in;

   // payload state
   aba_pkg::req_type                    req_ff, req_in;
   aba_pkg::rsp_type                    rsp_ff, rsp_in;
   logic [aba_pkg::ROUND_BITS-1:0]      sz_ff, sz_in;
   logic [aba_pkg::ROUND_BITS-1:0]      ofs_ff, ofs_in;
   logic [aba_pkg::ROUND_BITS-1:0]      div_num_ff, div_num_in;
   logic [aba_pkg::ROUND_BITS-1:0]      div_dvd_ff, div_dvd_in;
   logic [aba_pkg::FIELD_BITS-1:0]      div_rem_ff, div_rem_in;

   // datapath
   logic                                out_free;
   logic [aba_pkg::FIELD_BITS-1:0]      align_m1;
   logic                                not_pow2;
   logic [aba_pkg::ROUND_BITS-1:0]      mask_sz;
   logic [aba_pkg::ROUND_BITS-1:0]      mask_ofs;
   logic [aba_pkg::ROUND_BITS-1:0]      size_dvd;
   logic [aba_pkg::ROUND_BITS-1:0]      ofs_dvd;
   logic [aba_pkg::ROUND_BITS-1:0]      div_trial;
   logic                                div_ge;
   logic [aba_pkg::FIELD_BITS-1:0]      div_rem_next;
   logic [aba_pkg::ROUND_BITS-1:0]      div_round;
   logic [aba_pkg::SUM_BITS-1:0]        total;
   logic                                fits;

   assign req_ready = (state_ff == aba_pkg::S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // response register free this cycle (empty or being drained)
   assign out_free = !rsp_valid_ff || rsp_ready;

   // mask rounding for power-of-two alignments
   assign align_m1 = req_ff.align_bytes - aba_pkg::FIELD_BITS'(1);
   assign not_pow2 = |(align_m1 & req_ff.align_bytes);
   assign mask_sz  = ({1'b0, req_ff.request_bytes} + {1'b0, align_m1})
                     & ~{1'b0, align_m1};
   assign mask_ofs = ({1'b0, aba_pkg::FIELD_BITS'(next_ofs_ff)} + {1'b0, align_m1})
                     & ~{1'b0, align_m1};

   // dividends for round-up: v + a - 1 (alignment is nonzero here)
   assign size_dvd = {1'b0, req_ff.request_bytes} + {1'b0, align_m1};
   assign ofs_dvd  = {1'b0, aba_pkg::FIELD_BITS'(next_ofs_ff)} + {1'b0, align_m1};

   // one restoring divider step; only the remainder is needed since
   // ceil(v / a) * a equals (v + a - 1) minus its remainder
   assign div_trial    = {div_rem_ff, div_num_ff[aba_pkg::ROUND_BITS-1]};
   assign div_ge       = div_trial >= {1'b0, req_ff.align_bytes};
   assign div_rem_next = div_ge
                         ? aba_pkg::FIELD_BITS'(div_trial - {1'b0, req_ff.align_bytes})
                         : div_trial[aba_pkg::FIELD_BITS-1:0];
   assign div_round    = div_dvd_ff - {1'b0, div_rem_next};

   // fit test without wrap
   assign total = {1'b0, ofs_ff} + {1'b0, sz_ff};
   assign fits  = total <= {2'b00, cap_ff};

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      next_ofs_in  = next_ofs_ff;
      div_cnt_in   = div_cnt_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      sz_in        = sz_ff;
      ofs_in       = ofs_ff;
      div_num_in   = div_num_ff;
      div_dvd_in   = div_dvd_ff;
      div_rem_in   = div_rem_ff;

      // drain the output register
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         aba_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = aba_pkg::S_DECODE;
            end
         end

         aba_pkg::S_DECODE: begin
            priority if (req_ff.kind == aba_pkg::KIND_CLEAR) begin
               if (out_free) begin
                  next_ofs_in  = '0;
                  rsp_in       = '{aba_pkg::STATUS_OK, '0, '0, base_ff};
                  rsp_valid_in = 1'b1;
                  state_in     = aba_pkg::S_IDLE;
               end
            end else if (req_ff.kind == aba_pkg::KIND_NOP) begin
               if (out_free) begin
                  rsp_in       = '{aba_pkg::STATUS_OK, '0, '0, '0};
                  rsp_valid_in = 1'b1;
                  state_in     = aba_pkg::S_IDLE;
               end
            end else if (req_ff.align_bytes == '0) begin
               // zero alignment is checked first in both modes
               if (out_free) begin
                  rsp_in       = '{aba_pkg::STATUS_ZERO, '0, '0, '0};
                  rsp_valid_in = 1'b1;
                  state_in     = aba_pkg::S_IDLE;
               end
            end else if (req_ff.kind == aba_pkg::KIND_POW2) begin
               if (not_pow2) begin
                  if (out_free) begin
                     rsp_in       = '{aba_pkg::STATUS_NOT_POW2, '0, '0, '0};
                     rsp_valid_in = 1'b1;
                     state_in     = aba_pkg::S_IDLE;
                  end
               end else begin
                  sz_in    = mask_sz;
                  ofs_in   = mask_ofs;
                  state_in = aba_pkg::S_CHECK;
               end
            end else begin
               // any alignment: divide the size first
               div_num_in = size_dvd;
               div_dvd_in = size_dvd;
               div_rem_in = '0;
               div_cnt_in = aba_pkg::CNT_BITS'(aba_pkg::DIV_STEPS - 1);
               state_in   = aba_pkg::S_DIV_SIZE;
            end
         end

         aba_pkg::S_DIV_SIZE: begin
            div_num_in = div_num_ff << 1;
            div_rem_in = div_rem_next;
            div_cnt_in = div_cnt_ff - aba_pkg::CNT_BITS'(1);
            if (div_cnt_ff == '0) begin
               sz_in      = div_round;
               // reload for the offset
               div_num_in = ofs_dvd;
               div_dvd_in = ofs_dvd;
               div_rem_in = '0;
               div_cnt_in = aba_pkg::CNT_BITS'(aba_pkg::DIV_STEPS - 1);
               state_in   = aba_pkg::S_DIV_OFS;
            end
         end

         aba_pkg::S_DIV_OFS: begin
            div_num_in = div_num_ff << 1;
            div_rem_in = div_rem_next;
            div_cnt_in = div_cnt_ff - aba_pkg::CNT_BITS'(1);
            if (div_cnt_ff == '0) begin
               ofs_in   = div_round;
               state_in = aba_pkg::S_CHECK;
            end
         end

         aba_pkg::S_CHECK: begin
            if (out_free) begin
               if (fits) begin
                  // total <= capacity, so offset and size fit the field width
                  next_ofs_in = aba_pkg::OFFSET_BITS'(total);
                  rsp_in      = '{aba_pkg::STATUS_OK,
                                  ofs_ff[aba_pkg::FIELD_BITS-1:0],
                                  sz_ff[aba_pkg::FIELD_BITS-1:0],
                                  base_ff + aba_pkg::ADDR_BITS'(ofs_ff[aba_pkg::FIELD_BITS-1:0])};
               end else begin
                  rsp_in = '{aba_pkg::STATUS_OOM, '0, '0, '0};
               end
               rsp_valid_in = 1'b1;
               state_in     = aba_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = aba_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aba_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         next_ofs_ff  <= '0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         next_ofs_ff  <= next_ofs_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= aba_pkg::CAPACITY_RESET;
         base_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == aba_pkg::CSR_CAPACITY) begin
            cap_ff <= csr_wdata[aba_pkg::FIELD_BITS-1:0];
         end
         if (csr_index == aba_pkg::CSR_BASE) begin
            base_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      sz_ff      <= sz_in;
      ofs_ff     <= ofs_in;
      div_num_ff <= div_num_in;
      div_dvd_ff <= div_dvd_in;
      div_rem_ff <= div_rem_in;
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

// testbench for aligned_bump_allocator_top: directed and random request beats,
// each grant beat checked against an in-bench allocation predictor
// depends on aba_pkg for the beat structs, operation, status and register codes

module tb;
   import aba_pkg::*;

   localparam int STALL_LIMIT  = 4000;   // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 64;
   localparam int IDLE_PERCENT = 38;

   // indexes past the two real registers, the block must ignore them
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_A = CSR_IDX_BITS'(2);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_B = CSR_IDX_BITS'(3);

   // predicts every grant beat from the accepted request beats and holds the
   // predictions in order until the block hands its grant beats back
   class grant_tracker;
      logic [FIELD_BITS-1:0]  capacity;
      logic [ADDR_BITS-1:0]   base;
      logic [OFFSET_BITS-1:0] next_free;
      rsp_type                pending_grants[$];
      int                     requests;
      int                     grants;
      int                     errors;

      function new();
         capacity  = CAPACITY_RESET;
         base      = '0;
         next_free = '0;
         requests  = 0;
         grants    = 0;
         errors    = 0;
      endfunction

      function void write_register(logic [CSR_IDX_BITS-1:0] csr_idx,
                                   logic [ADDR_BITS-1:0] data);
         if (csr_idx == CSR_CAPACITY) begin
            capacity = data[FIELD_BITS-1:0];
         end else if (csr_idx == CSR_BASE) begin
            base = data;
         end
      endfunction

      function rsp_type predict_grant(req_type r);
         rsp_type     g;
         logic [63:0] want_bytes;
         logic [63:0] align;
         logic [63:0] mask;
         logic [63:0] sz;
         logic [63:0] ofs;
         logic [63:0] block_end;
         g          = '0;
         g.status   = STATUS_OK;
         want_bytes = 64'(r.request_bytes);
         align      = 64'(r.align_bytes);
         case (r.kind)
            KIND_CLEAR: begin
               next_free        = '0;
               g.device_address = base;
            end
            KIND_NOP: begin
            end
            KIND_POW2, KIND_ANY: begin
               if (align == 0) begin
                  g.status = STATUS_ZERO;
               end else if (r.kind == KIND_POW2 && (align & (align - 1)) != 0) begin
                  g.status = STATUS_NOT_POW2;
               end else begin
                  if (r.kind == KIND_POW2) begin
                     mask = align - 1;
                     sz   = (want_bytes + mask) & ~mask;
                     ofs  = (64'(next_free) + mask) & ~mask;
                  end else begin
                     sz  = ((want_bytes + align - 1) / align) * align;
                     ofs = ((64'(next_free) + align - 1) / align) * align;
                  end
                  // fit test is done on the unwrapped sum
                  block_end = ofs + sz;
                  if (block_end > 64'(capacity)) begin
                     g.status = STATUS_OOM;
                  end else begin
                     next_free        = OFFSET_BITS'(block_end);
                     g.block_offset   = FIELD_BITS'(ofs);
                     g.block_bytes    = FIELD_BITS'(sz);
                     g.device_address = base + ADDR_BITS'(ofs);
                  end
               end
            end
         endcase
         return g;
      endfunction

      function void note_request(req_type r);
         pending_grants.push_back(predict_grant(r));
         requests++;
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_grant(rsp_type got);
         rsp_type want;
         if (pending_grants.size() == 0) begin
            $display("%0t: grant beat with nothing outstanding, expected none actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = pending_grants.pop_front();
         grants++;
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("block_offset", 64'(want.block_offset), 64'(got.block_offset));
         compare_field("block_bytes", 64'(want.block_bytes), 64'(got.block_bytes));
         compare_field("device_address", 64'(want.device_address),
                       64'(got.device_address));
      endfunction

      function int pending();
         return pending_grants.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   req_type                 req_data;
   logic                    rsp_valid;
   logic                    rsp_ready;
   rsp_type                 rsp_data;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [ADDR_BITS-1:0]    csr_wdata;

   grant_tracker tracker;
   bit           calm_phase;       // set for the stretch where neither side idles
   int           register_writes;
   int           settings_used;
   int           directed_count;

   aligned_bump_allocator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 8 ns period
   initial begin
      forever #4 clock = ~clock;
   end

   function automatic req_type make_request(logic [1:0] kind, logic [FIELD_BITS-1:0] bytes,
                                            logic [FIELD_BITS-1:0] align);
      req_type r;
      r.kind          = kind;
      r.request_bytes = bytes;
      r.align_bytes   = align;
      return r;
   endfunction

   function automatic logic [ADDR_BITS-1:0] random_address();
      return ADDR_BITS'({$urandom(), $urandom()});
   endfunction

   // mostly well-formed allocations sized against the current capacity, with
   // a clear every few beats so the offset keeps cycling through the region;
   // the rest is zero alignments, odd masks and full-range noise
   function automatic req_type random_request(logic [FIELD_BITS-1:0] cap);
      req_type     r;
      int unsigned pick;
      int unsigned span;
      span = int'(cap);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         r.kind = KIND_POW2;
      end else if (pick < 75) begin
         r.kind = KIND_ANY;
      end else if (pick < 92) begin
         r.kind = KIND_CLEAR;
      end else begin
         r.kind = KIND_NOP;
      end

      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         r.request_bytes = FIELD_BITS'($urandom_range(0, span / 32 + 8));
      end else if (pick < 85) begin
         r.request_bytes = FIELD_BITS'($urandom_range(0, span / 4 + 8));
      end else if (pick < 95) begin
         r.request_bytes = FIELD_BITS'($urandom_range(0, span));
      end else begin
         r.request_bytes = FIELD_BITS'($urandom());
      end

      pick = $urandom_range(0, 99);
      if (r.kind == KIND_POW2) begin
         if (pick < 80) begin
            r.align_bytes = FIELD_BITS'(1) << $urandom_range(0, 12);
         end else if (pick < 88) begin
            r.align_bytes = FIELD_BITS'(1) << $urandom_range(13, FIELD_BITS - 1);
         end else if (pick < 93) begin
            r.align_bytes = '0;
         end else begin
            r.align_bytes = FIELD_BITS'($urandom());
         end
      end else begin
         if (pick < 60) begin
            r.align_bytes = FIELD_BITS'($urandom_range(1, 100));
         end else if (pick < 80) begin
            r.align_bytes = FIELD_BITS'($urandom_range(1, 5000));
         end else if (pick < 90) begin
            r.align_bytes = FIELD_BITS'(1) << $urandom_range(0, FIELD_BITS - 1);
         end else if (pick < 95) begin
            r.align_bytes = '0;
         end else begin
            r.align_bytes = FIELD_BITS'($urandom());
         end
      end
      return r;
   endfunction

   // one request beat: random idle cycles first (valid low), then valid held
   // with a stable payload until the beat is taken
   task automatic send_request(input req_type item);
      while (!calm_phase && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(item);
   endtask

   // leaves csr_valid high so back-to-back writes do not toggle it in one step
   task automatic csr_beat(input logic [CSR_IDX_BITS-1:0] csr_idx,
                           input logic [ADDR_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= csr_idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_register(csr_idx, data);
      register_writes++;
   endtask

   task automatic program_registers(input logic [ADDR_BITS-1:0] cap_word,
                                    input logic [ADDR_BITS-1:0] base_word,
                                    input bit spare);
      csr_beat(CSR_CAPACITY, cap_word);
      csr_beat(CSR_BASE, base_word);
      if (spare) begin
         csr_beat(CSR_SPARE_A, random_address());
         csr_beat(CSR_SPARE_B, random_address());
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // registers only change once every grant beat is back, which leaves the
   // block idle since each request beat yields exactly one grant beat
   task automatic run_phase(input logic [ADDR_BITS-1:0] cap_word,
                            input logic [ADDR_BITS-1:0] base_word,
                            input int count, input bit calm, input bit spare);
      while (tracker.pending() != 0) @(posedge clock);
      calm_phase <= calm;
      program_registers(cap_word, base_word, spare);
      repeat (count) send_request(random_request(tracker.capacity));
      req_valid <= 1'b0;
   endtask

   // directed beats run on the reset settings: full 24 bit capacity, base 0
   task automatic run_directed();
      send_request(make_request(KIND_CLEAR, '0, '0));
      send_request(make_request(KIND_POW2, '0, 24'd1));          // empty block at 0
      send_request(make_request(KIND_POW2, 24'd1, '0));          // zero alignment, mask mode
      send_request(make_request(KIND_ANY, 24'd1, '0));           // zero alignment, divide mode
      send_request(make_request(KIND_POW2, 24'd5, 24'd3));       // not a power of two
      send_request(make_request(KIND_POW2, '1, '1));
      send_request(make_request(KIND_ANY, 24'd100, 24'd3));
      send_request(make_request(KIND_POW2, 24'd1, 24'd16));
      send_request(make_request(KIND_ANY, '1, '1));              // offset rounding overflows
      send_request(make_request(KIND_POW2, '1, 24'h800000));     // size rounds past 24 bits
      send_request(make_request(KIND_NOP, '1, '1));
      send_request(make_request(KIND_NOP, '0, '0));
      send_request(make_request(KIND_CLEAR, '1, '1));
      send_request(make_request(KIND_POW2, '1, 24'd1));          // fills the region exactly
      send_request(make_request(KIND_POW2, '0, 24'd1));          // empty block at the top
      send_request(make_request(KIND_ANY, '0, 24'd7));
      send_request(make_request(KIND_POW2, 24'd1, 24'd2));       // out of memory
      send_request(make_request(KIND_ANY, 24'd1, 24'd1));
      send_request(make_request(KIND_CLEAR, '0, '0));
      send_request(make_request(KIND_ANY, 24'h800001, 24'h800000));
      send_request(make_request(KIND_POW2, 24'd1, 24'h800000));
      send_request(make_request(KIND_ANY, 24'd3, '1));
      send_request(make_request(KIND_ANY, '0, '1));
      send_request(make_request(KIND_CLEAR, '0, '0));
      req_valid <= 1'b0;
      directed_count = tracker.requests;
   endtask

   // grant side: random stalls on rsp_ready, every taken beat is checked
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            tracker.check_grant(rsp_data);
         end
         rsp_ready <= calm_phase || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // watchdog: counts cycles with no handshake on any channel
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      tracker         = new();
      register_writes = 0;
      settings_used   = 0;
      directed_count  = 0;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_data   <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_CAPACITY;
      csr_wdata  <= '0;
      calm_phase <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // capacity words carry random upper bits, only the low 24 count
      // full region, base at the top of the address space so addresses wrap
      run_phase({FIELD_BITS'($urandom()), 24'hFFFFFF}, '1, 230, 1'b0, 1'b1);
      // empty region: only empty blocks at offset 0 can be granted
      run_phase({FIELD_BITS'($urandom()), 24'h000000}, random_address(), 150, 1'b0, 1'b0);
      // small region, no idling on either side for the whole phase
      run_phase(ADDR_BITS'(4096), random_address(), 250, 1'b1, 1'b0);
      // capacity likely dropped below the running offset left by the last phase
      run_phase(ADDR_BITS'(300), '0, 200, 1'b0, 1'b0);
      run_phase(random_address(), random_address(), 250, 1'b0, 1'b0);
      run_phase(ADDR_BITS'(65536), 48'hFFFF_FFFF_0000, 250, 1'b0, 1'b0);
      run_phase(ADDR_BITS'(1), random_address(), 150, 1'b0, 1'b1);
      run_phase(ADDR_BITS'(24'hFFFFFF), '0, 370, 1'b0, 1'b0);

      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d request beats (%0d directed, the rest random) gave %0d grant beats",
               tracker.requests, directed_count, tracker.grants);
      $display("%0d register writes over %0d settings, %0d mismatches",
               register_writes, settings_used, tracker.errors);
      if (tracker.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
